[hdl/tcw_pkg.sv]
// Shared types and constants for the text console writer.
// Used by the controller, the datapath and the top level.
`default_nettype none

package tcw_pkg;

    localparam int ADDR_W      = 3;
    localparam int DATA_W      = 32;
    localparam int CHAR_W      = 8;
    localparam int COLOR_W     = 4;
    localparam int ROW_FIELD_W = 5;
    localparam int COL_FIELD_W = 7;
    localparam int CELL_W      = 2 * CHAR_W;
    localparam int REG_IDX_BIT = 2;

    localparam logic [1:0] CMD_PUT   = 2'd0;
    localparam logic [1:0] CMD_READ  = 2'd1;
    localparam logic [1:0] CMD_CLEAR = 2'd2;

    localparam logic REG_FG = 1'b0;
    localparam logic REG_BG = 1'b1;

    localparam logic [CHAR_W-1:0] CH_LF     = 8'h0A;
    localparam logic [CHAR_W-1:0] CH_BS     = 8'h08;
    localparam logic [CHAR_W-1:0] CH_CR     = 8'h0D;
    localparam logic [CHAR_W-1:0] CH_NUL    = 8'h00;
    localparam logic [CHAR_W-1:0] CH_SPACE  = 8'h20;
    localparam logic [CHAR_W-1:0] CH_BSLASH = 8'h5C;
    localparam logic [CHAR_W-1:0] CH_ZERO   = 8'h30;

    localparam logic [CHAR_W-1:0]  ATTR_RESET = 8'h0F;
    localparam logic [COLOR_W-1:0] FG_RESET   = 4'hF;
    localparam logic [COLOR_W-1:0] BG_RESET   = 4'h0;

    // cell write sources
    localparam logic [2:0] WR_NONE  = 3'd0;
    localparam logic [2:0] WR_CHAR  = 3'd1;
    localparam logic [2:0] WR_BS    = 3'd2;
    localparam logic [2:0] WR_BLANK = 3'd3;
    localparam logic [2:0] WR_INIT  = 3'd4;

    // character register sources
    localparam logic [1:0] CHS_IN     = 2'd0;
    localparam logic [1:0] CHS_BSLASH = 2'd1;
    localparam logic [1:0] CHS_ZERO   = 2'd2;

    typedef struct packed {
        logic       take;
        logic       ld_read;
        logic       ld_char;
        logic [1:0] char_sel;
        logic       col_clr;
        logic       col_inc;
        logic       col_dec;
        logic       row_inc;
        logic       ptr_clr;
        logic       ptr_inc;
        logic       copy_rd;
        logic [2:0] wr_sel;
        logic       finish;
    } tcw_cmd_t;

    typedef struct packed {
        logic col_full;
        logic at_col0;
        logic last_row;
        logic scroll_end;
        logic sweep_end;
        logic out_free;
    } tcw_stat_t;

endpackage

`default_nettype wire

[hdl/tcw_ram.sv]
// Generic single write port, single read port RAM with registered read.
// No dependencies.
`default_nettype none

module tcw_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2000,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic             re,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

[hdl/tcw_ctrl.sv]
// Controller state machine of the text console writer.
// Depends on tcw_pkg; drives the datapath through tcw_cmd_t.
`default_nettype none

module tcw_ctrl
    import tcw_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              item_valid,
    input  wire logic [1:0]        cmd,
    input  wire logic [CHAR_W-1:0] char_code,
    output logic                   item_stall,
    output tcw_cmd_t               dp_cmd,
    input  wire tcw_stat_t         dp_stat
);

    localparam logic [2:0] S_INIT   = 3'd0;
    localparam logic [2:0] S_IDLE   = 3'd1;
    localparam logic [2:0] S_WRITE  = 3'd2;
    localparam logic [2:0] S_SCROLL = 3'd3;
    localparam logic [2:0] S_BLANK  = 3'd4;
    localparam logic [2:0] S_READ   = 3'd5;
    localparam logic [2:0] S_DONE   = 3'd6;

    logic [2:0] state_reg;
    logic [2:0] state_next;
    logic       wrap_reg;
    logic       wrap_next;
    logic       nul2_reg;
    logic       nul2_next;
    tcw_cmd_t   c;

    always_comb
    begin
        state_next = state_reg;
        wrap_next  = wrap_reg;
        nul2_next  = nul2_reg;
        c          = '0;
        unique case (state_reg)
            S_INIT:
            begin
                c.wr_sel = WR_INIT;
                if (dp_stat.sweep_end)
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    c.ptr_inc = 1'b1;
                end
            end
            S_IDLE:
            begin
                if (item_valid)
                begin
                    c.take    = 1'b1;
                    wrap_next = 1'b0;
                    nul2_next = 1'b0;
                    unique case (cmd)
                        CMD_PUT:
                        begin
                            priority case (char_code)
                                CH_LF:
                                begin
                                    c.col_clr = 1'b1;
                                    if (dp_stat.last_row)
                                    begin
                                        c.ptr_clr  = 1'b1;
                                        state_next = S_SCROLL;
                                    end
                                    else
                                    begin
                                        c.row_inc  = 1'b1;
                                        state_next = S_DONE;
                                    end
                                end
                                CH_BS:
                                begin
                                    if (!dp_stat.at_col0)
                                    begin
                                        c.wr_sel  = WR_BS;
                                        c.col_dec = 1'b1;
                                    end
                                    state_next = S_DONE;
                                end
                                CH_CR:
                                begin
                                    c.col_clr  = 1'b1;
                                    state_next = S_DONE;
                                end
                                CH_NUL:
                                begin
                                    c.ld_char  = 1'b1;
                                    c.char_sel = CHS_BSLASH;
                                    nul2_next  = 1'b1;
                                    state_next = S_WRITE;
                                end
                                default:
                                begin
                                    c.ld_char  = 1'b1;
                                    c.char_sel = CHS_IN;
                                    state_next = S_WRITE;
                                end
                            endcase
                        end
                        CMD_READ:
                        begin
                            c.ld_read  = 1'b1;
                            state_next = S_READ;
                        end
                        CMD_CLEAR:
                        begin
                            c.ptr_clr  = 1'b1;
                            state_next = S_BLANK;
                        end
                        default:
                        begin
                            state_next = S_DONE;
                        end
                    endcase
                end
            end
            S_WRITE:
            begin
                if (dp_stat.col_full)
                begin
                    c.col_clr = 1'b1;
                    if (dp_stat.last_row)
                    begin
                        c.ptr_clr  = 1'b1;
                        wrap_next  = 1'b1;
                        state_next = S_SCROLL;
                    end
                    else
                    begin
                        c.row_inc = 1'b1;
                    end
                end
                else
                begin
                    c.wr_sel  = WR_CHAR;
                    c.col_inc = 1'b1;
                    if (nul2_reg)
                    begin
                        c.ld_char  = 1'b1;
                        c.char_sel = CHS_ZERO;
                        nul2_next  = 1'b0;
                    end
                    else if (dp_stat.out_free)
                    begin
                        c.finish   = 1'b1;
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        state_next = S_DONE;
                    end
                end
            end
            S_SCROLL:
            begin
                if (dp_stat.scroll_end)
                begin
                    state_next = S_BLANK;
                end
                else
                begin
                    c.copy_rd = 1'b1;
                    c.ptr_inc = 1'b1;
                end
            end
            S_BLANK:
            begin
                c.wr_sel = WR_BLANK;
                if (dp_stat.sweep_end)
                begin
                    if (wrap_reg)
                    begin
                        wrap_next  = 1'b0;
                        state_next = S_WRITE;
                    end
                    else
                    begin
                        state_next = S_DONE;
                    end
                end
                else
                begin
                    c.ptr_inc = 1'b1;
                end
            end
            S_READ:
            begin
                if (dp_stat.out_free)
                begin
                    c.finish   = 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (dp_stat.out_free)
                begin
                    c.finish   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_INIT;
            wrap_reg  <= 1'b0;
            nul2_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            wrap_reg  <= wrap_next;
            nul2_reg  <= nul2_next;
        end
    end

    assign item_stall = (state_reg != S_IDLE);
    assign dp_cmd     = c;

    a_finish_free: assert property (@(posedge clk) disable iff (!rst_n)
        dp_cmd.finish |-> dp_stat.out_free)
        else $error("result loaded while output register busy");

    a_write_in_line: assert property (@(posedge clk) disable iff (!rst_n)
        (dp_cmd.wr_sel == WR_CHAR) |-> !dp_stat.col_full)
        else $error("character written past line end");

    a_copy_bound: assert property (@(posedge clk) disable iff (!rst_n)
        dp_cmd.copy_rd |-> !dp_stat.scroll_end)
        else $error("scroll copy read beyond last row");

endmodule

`default_nettype wire

[hdl/tcw_dp.sv]
// Datapath of the text console writer: cell RAM, cursor, sweep pointer,
// color registers and result register. Depends on tcw_pkg and tcw_ram.
`default_nettype none

module tcw_dp
    import tcw_pkg::*;
#(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire tcw_cmd_t               cmd,
    output tcw_stat_t                   stat,
    input  wire logic [CHAR_W-1:0]      char_code,
    input  wire logic [ROW_FIELD_W-1:0] cell_row,
    input  wire logic [COL_FIELD_W-1:0] cell_col,
    input  wire logic                   psel,
    input  wire logic                   penable,
    input  wire logic                   pwrite,
    input  wire logic [ADDR_W-1:0]      paddr,
    input  wire logic [DATA_W-1:0]      pwdata,
    output logic      [DATA_W-1:0]      prdata,
    input  wire logic                   result_stall,
    output logic                        result_valid,
    output logic      [CHAR_W-1:0]      cell_char,
    output logic      [CHAR_W-1:0]      cell_color,
    output logic      [ROW_FIELD_W-1:0] cursor_row,
    output logic      [COL_FIELD_W-1:0] cursor_col
);

    localparam int CW         = $clog2(COLUMNS + 1);
    localparam int RW         = $clog2(ROWS);
    localparam int TOTAL      = ROWS * COLUMNS;
    localparam int AW         = $clog2(TOTAL);
    localparam int SCROLL_END = (ROWS - 1) * COLUMNS;

    logic [COLOR_W-1:0]     fg_reg;
    logic [COLOR_W-1:0]     bg_reg;
    logic [RW-1:0]          cur_row_reg;
    logic [RW-1:0]          cur_row_next;
    logic [CW-1:0]          cur_col_reg;
    logic [CW-1:0]          cur_col_next;
    logic [AW-1:0]          ptr_reg;
    logic [AW-1:0]          ptr_next;
    logic                   pend_valid_reg;
    logic [AW-1:0]          pend_addr_reg;
    logic [CHAR_W-1:0]      char_reg;
    logic [CHAR_W-1:0]      char_next;
    logic                   hit_reg;
    logic                   out_valid_reg;
    logic [CHAR_W-1:0]      cell_char_reg;
    logic [CHAR_W-1:0]      cell_color_reg;
    logic [ROW_FIELD_W-1:0] cursor_row_reg;
    logic [COL_FIELD_W-1:0] cursor_col_reg;

    logic [CHAR_W-1:0]      attr;
    logic [AW-1:0]          cur_addr;
    logic [AW-1:0]          in_addr;
    logic                   in_range;
    logic                   cfg_we;
    logic                   cfg_idx;
    logic [COLOR_W-1:0]     cfg_rd;
    logic [31:0]            row_ext;
    logic [31:0]            col_ext;

    logic                   ram_we;
    logic [AW-1:0]          ram_waddr;
    logic [CELL_W-1:0]      ram_wdata;
    logic                   ram_re;
    logic [AW-1:0]          ram_raddr;
    logic [CELL_W-1:0]      ram_rdata;

    assign attr     = {bg_reg, fg_reg};
    assign cur_addr = AW'(32'(cur_row_reg) * COLUMNS + 32'(cur_col_reg));
    assign in_addr  = AW'(32'(cell_row) * COLUMNS + 32'(cell_col));
    assign in_range = (32'(cell_row) < ROWS) && (32'(cell_col) < COLUMNS);

    // configuration registers
    assign cfg_we  = psel && penable && pwrite;
    assign cfg_idx = paddr[REG_IDX_BIT];

    always_comb
    begin
        unique case (cfg_idx)
            REG_FG:  cfg_rd = fg_reg;
            REG_BG:  cfg_rd = bg_reg;
            default: cfg_rd = fg_reg;
        endcase
    end

    assign prdata = DATA_W'(cfg_rd);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fg_reg <= FG_RESET;
            bg_reg <= BG_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_idx)
                REG_FG:  fg_reg <= pwdata[COLOR_W-1:0];
                REG_BG:  bg_reg <= pwdata[COLOR_W-1:0];
                default: fg_reg <= fg_reg;
            endcase
        end
    end

    // cursor and sweep pointer
    always_comb
    begin
        cur_col_next = cur_col_reg;
        priority if (cmd.col_clr)
        begin
            cur_col_next = '0;
        end
        else if (cmd.col_inc)
        begin
            cur_col_next = cur_col_reg + CW'(1);
        end
        else if (cmd.col_dec)
        begin
            cur_col_next = cur_col_reg - CW'(1);
        end
        cur_row_next = cmd.row_inc ? cur_row_reg + RW'(1) : cur_row_reg;
        ptr_next     = cmd.ptr_clr ? '0 : (cmd.ptr_inc ? ptr_reg + AW'(1) : ptr_reg);
    end

    always_comb
    begin
        char_next = char_reg;
        if (cmd.ld_char)
        begin
            unique case (cmd.char_sel)
                CHS_IN:     char_next = char_code;
                CHS_BSLASH: char_next = CH_BSLASH;
                CHS_ZERO:   char_next = CH_ZERO;
                default:    char_next = char_code;
            endcase
        end
    end

    // RAM ports: a pending scroll copy owns the write port
    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = ptr_reg;
        ram_wdata = {attr, CH_SPACE};
        if (pend_valid_reg)
        begin
            ram_we    = 1'b1;
            ram_waddr = pend_addr_reg;
            ram_wdata = ram_rdata;
        end
        else
        begin
            unique case (cmd.wr_sel)
                WR_NONE:
                begin
                    ram_we = 1'b0;
                end
                WR_CHAR:
                begin
                    ram_we    = 1'b1;
                    ram_waddr = cur_addr;
                    ram_wdata = {attr, char_reg};
                end
                WR_BS:
                begin
                    ram_we    = 1'b1;
                    ram_waddr = cur_addr - AW'(1);
                    ram_wdata = {attr, CH_SPACE};
                end
                WR_BLANK:
                begin
                    ram_we    = 1'b1;
                    ram_waddr = ptr_reg;
                    ram_wdata = {attr, CH_SPACE};
                end
                WR_INIT:
                begin
                    ram_we    = 1'b1;
                    ram_waddr = ptr_reg;
                    ram_wdata = {ATTR_RESET, CH_SPACE};
                end
                default:
                begin
                    ram_we = 1'b0;
                end
            endcase
        end
    end

    assign ram_re    = cmd.ld_read || cmd.copy_rd;
    assign ram_raddr = cmd.ld_read ? in_addr : AW'(32'(ptr_reg) + COLUMNS);

    tcw_ram #(
        .WIDTH(CELL_W),
        .DEPTH(TOTAL)
    ) u_cells (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_row_reg    <= '0;
            cur_col_reg    <= '0;
            ptr_reg        <= '0;
            pend_valid_reg <= 1'b0;
            hit_reg        <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            cur_row_reg    <= cur_row_next;
            cur_col_reg    <= cur_col_next;
            ptr_reg        <= ptr_next;
            pend_valid_reg <= cmd.copy_rd;
            if (cmd.take)
            begin
                hit_reg <= cmd.ld_read && in_range;
            end
            if (cmd.finish)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!result_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign row_ext = 32'(cur_row_next);
    assign col_ext = 32'(cur_col_next);

    always_ff @(posedge clk)
    begin
        char_reg      <= char_next;
        pend_addr_reg <= ptr_reg;
        if (cmd.finish)
        begin
            cell_char_reg  <= hit_reg ? ram_rdata[CHAR_W-1:0] : '0;
            cell_color_reg <= hit_reg ? ram_rdata[CELL_W-1:CHAR_W] : '0;
            cursor_row_reg <= row_ext[ROW_FIELD_W-1:0];
            cursor_col_reg <= col_ext[COL_FIELD_W-1:0];
        end
    end

    assign stat.col_full   = (32'(cur_col_reg) >= COLUMNS);
    assign stat.at_col0    = (cur_col_reg == '0);
    assign stat.last_row   = (32'(cur_row_reg) == ROWS - 1);
    assign stat.scroll_end = (32'(ptr_reg) == SCROLL_END);
    assign stat.sweep_end  = (32'(ptr_reg) == TOTAL - 1);
    assign stat.out_free   = !out_valid_reg || !result_stall;

    assign result_valid = out_valid_reg;
    assign cell_char    = cell_char_reg;
    assign cell_color   = cell_color_reg;
    assign cursor_row   = cursor_row_reg;
    assign cursor_col   = cursor_col_reg;

    a_copy_port: assert property (@(posedge clk) disable iff (!rst_n)
        pend_valid_reg |-> (cmd.wr_sel == WR_NONE))
        else $error("scroll copy collides with cell write");

    a_col_bound: assert property (@(posedge clk) disable iff (!rst_n)
        32'(cur_col_reg) <= COLUMNS)
        else $error("cursor column beyond line end");

    a_row_bound: assert property (@(posedge clk) disable iff (!rst_n)
        32'(cur_row_reg) < ROWS)
        else $error("cursor row beyond last row");

endmodule

`default_nettype wire

[hdl/text_console_writer.sv]
// Text console writer over a ROWS x COLUMNS cell store (default 25 x 80).
// Depends on tcw_pkg, tcw_ctrl, tcw_dp (and through it tcw_ram).
//
// Input channel (item_valid / item_stall) takes one command word: put a
// character, read one cell, or clear the screen. Output channel
// (result_valid / result_stall) returns exactly one word per command: the
// cell for an in-range read (zero otherwise) and the cursor after the command.
// Colors are set through the APB port: fg_color at 0x0, bg_color at 0x4.
//
// Commands are handled one at a time: item_stall stays high after an
// accept until the result is loaded. An LF on the last row, or a byte that
// wraps past the last row, scrolls: one cell is copied per cycle through
// the single write port of the cell RAM, then the last row is blanked;
// clear sweeps all cells.
// After reset a clearing pass over all cells holds item_stall high; the
// cursor is at row 0, column 0. A stalled result is held in the output
// register; one more command is accepted and then waits with item_stall
// high until that word is taken.
`default_nettype none

module text_console_writer
    import tcw_pkg::*;
#(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   psel,
    input  wire logic                   penable,
    input  wire logic                   pwrite,
    input  wire logic [ADDR_W-1:0]      paddr,
    input  wire logic [DATA_W-1:0]      pwdata,
    output logic      [DATA_W-1:0]      prdata,
    output logic                        pready,
    input  wire logic                   item_valid,
    output logic                        item_stall,
    input  wire logic [1:0]             cmd,
    input  wire logic [CHAR_W-1:0]      char_code,
    input  wire logic [ROW_FIELD_W-1:0] cell_row,
    input  wire logic [COL_FIELD_W-1:0] cell_col,
    output logic                        result_valid,
    input  wire logic                   result_stall,
    output logic      [CHAR_W-1:0]      cell_char,
    output logic      [CHAR_W-1:0]      cell_color,
    output logic      [ROW_FIELD_W-1:0] cursor_row,
    output logic      [COL_FIELD_W-1:0] cursor_col
);

    tcw_cmd_t  dp_cmd;
    tcw_stat_t dp_stat;

    assign pready = 1'b1;

    tcw_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .cmd        (cmd),
        .char_code  (char_code),
        .item_stall (item_stall),
        .dp_cmd     (dp_cmd),
        .dp_stat    (dp_stat)
    );

    tcw_dp #(
        .COLUMNS(COLUMNS),
        .ROWS   (ROWS)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (dp_cmd),
        .stat         (dp_stat),
        .char_code    (char_code),
        .cell_row     (cell_row),
        .cell_col     (cell_col),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .result_stall (result_stall),
        .result_valid (result_valid),
        .cell_char    (cell_char),
        .cell_color   (cell_color),
        .cursor_row   (cursor_row),
        .cursor_col   (cursor_col)
    );

endmodule

`default_nettype wire
